// ===== hdl/epra_pkg.sv =====
// shared constants for the echo pulse range averager
`default_nettype none
package epra_pkg;

   localparam int STAMP_W = 16;
   localparam int WIDTH_W = 17;
   localparam int DIST_W  = 9;
   localparam int COUNT_W = 2;

   // width / 148 as a multiply by ceil(2^25 / 148), exact for widths below 2^17
   localparam int RAW_SHIFT = 25;
   localparam int RAW_RECIP_W = 18;
   localparam logic [RAW_RECIP_W-1:0] RAW_RECIP = 18'd226720;

   localparam logic [COUNT_W-1:0] RISE_COUNT_FULL = 2'd2;
   localparam logic [DIST_W-1:0]  DIST_MAX = 9'd442;

endpackage
`default_nettype wire

// ===== hdl/epra_cell.sv =====
// one history cell: holds a distance and passes it on to the next cell
`default_nettype none
module epra_cell
   import epra_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift_en,
   input  wire logic [DIST_W-1:0] dist_prev,
   output logic      [DIST_W-1:0] dist_q
);

   logic [DIST_W-1:0] dist_ff;
   logic [DIST_W-1:0] dist_in;

   assign dist_in = shift_en ? dist_prev : dist_ff;
   assign dist_q  = dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= '0;
      end else begin
         dist_ff <= dist_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/echo_pulse_range_averager.sv =====
// top level: echo width, inch conversion, history cell chain and running average
// falling edges pass every stage and the output register on their way to rsp
// one transaction per cycle unless rsp_tready stalls; one history shift per result
// rising-edge transactions update the rise stamp and period and give no result
// reset (synchronous, active high) clears the rise stamp, period, rise count,
// all history cells, the running sum and every stage valid
`default_nettype none
module echo_pulse_range_averager
   import epra_pkg::*;
#(
   parameter int AVG_DEPTH = 6
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] stamp
   input  wire logic        req_tuser,   // [0] edge_rising
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata    // [16:0] pulse_width, [25:17] distance_raw,
                                         // [34:26] distance_avg, [51:35] echo_period,
                                         // [55:52] zero
);

   // running sum width and the reciprocal used for the mean
   localparam int SUM_W     = DIST_W + $clog2(AVG_DEPTH);
   localparam int AVG_K     = SUM_W + $clog2(AVG_DEPTH) + 1;
   localparam int RECIP_W   = AVG_K + 1;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'((2**AVG_K + AVG_DEPTH - 1) / AVG_DEPTH);
   localparam int AVG_PROD_W = SUM_W + RECIP_W;
   localparam int RAW_PROD_W = WIDTH_W + RAW_RECIP_W;
   localparam int PAD_W      = 56 - 2 * WIDTH_W - 2 * DIST_W;

   // modular span b - a, a zero difference counts as a full wrap
   function automatic logic [WIDTH_W-1:0] mod_span(input logic [STAMP_W-1:0] a,
                                                   input logic [STAMP_W-1:0] b);
      logic [STAMP_W-1:0] diff;
      diff = b - a;
      return {(diff == '0), diff};
   endfunction

   // pipeline moves as a whole whenever the output register can take a transaction
   logic advance;
   logic req_take;
   logic rise_take;
   logic fall_take;
   logic rsp_tvalid_ff, rsp_tvalid_in;

   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;
   assign req_take   = req_tvalid && advance;
   assign rise_take  = req_take && req_tuser;
   assign fall_take  = req_take && !req_tuser;

   // rise tracking state
   logic [STAMP_W-1:0] last_rise_ff, last_rise_in;
   logic [WIDTH_W-1:0] rise_period_ff, rise_period_in;
   logic [COUNT_W-1:0] rise_count_ff, rise_count_in;
   logic [WIDTH_W-1:0] span_now;

   assign span_now = mod_span(last_rise_ff, req_tdata);

   always_comb begin
      last_rise_in   = last_rise_ff;
      rise_period_in = rise_period_ff;
      rise_count_in  = rise_count_ff;
      if (rise_take) begin
         last_rise_in   = req_tdata;
         rise_period_in = span_now;
         if (rise_count_ff != RISE_COUNT_FULL) begin
            rise_count_in = rise_count_ff + 1'b1;
         end
      end
   end

   // stage 1: echo width and the period seen by this falling edge
   logic               s1_valid_ff, s1_valid_in;
   logic [WIDTH_W-1:0] s1_width_ff, s1_width_in;
   logic [WIDTH_W-1:0] s1_period_ff, s1_period_in;

   assign s1_valid_in  = advance ? fall_take : s1_valid_ff;
   assign s1_width_in  = advance ? span_now : s1_width_ff;
   assign s1_period_in = advance ?
                         ((rise_count_ff == RISE_COUNT_FULL) ? rise_period_ff : '0) :
                         s1_period_ff;

   // stage 2: inches through the reciprocal multiply
   logic [RAW_PROD_W-1:0] raw_prod;
   logic               s2_valid_ff, s2_valid_in;
   logic [DIST_W-1:0]  s2_raw_ff, s2_raw_in;
   logic [WIDTH_W-1:0] s2_width_ff, s2_width_in;
   logic [WIDTH_W-1:0] s2_period_ff, s2_period_in;

   assign raw_prod     = RAW_PROD_W'(s1_width_ff) * RAW_PROD_W'(RAW_RECIP);
   assign s2_valid_in  = advance ? s1_valid_ff : s2_valid_ff;
   assign s2_raw_in    = advance ? raw_prod[RAW_SHIFT+DIST_W-1:RAW_SHIFT] : s2_raw_ff;
   assign s2_width_in  = advance ? s1_width_ff : s2_width_ff;
   assign s2_period_in = advance ? s1_period_ff : s2_period_ff;

   // stage 3: history chain shifts in the new distance, running sum follows
   logic              hist_shift;
   logic [DIST_W-1:0] hist_q [AVG_DEPTH];

   assign hist_shift = advance && s2_valid_ff;

   for (genvar i = 0; i < AVG_DEPTH; i++) begin : g_hist
      if (i == 0) begin : g_head
         epra_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (hist_shift),
            .dist_prev (s2_raw_ff),
            .dist_q    (hist_q[i])
         );
      end else begin : g_body
         epra_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (hist_shift),
            .dist_prev (hist_q[i-1]),
            .dist_q    (hist_q[i])
         );
      end
   end

   // the oldest cell leaves the sum as the new distance enters it
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               s3_valid_ff, s3_valid_in;
   logic [DIST_W-1:0]  s3_raw_ff, s3_raw_in;
   logic [WIDTH_W-1:0] s3_width_ff, s3_width_in;
   logic [WIDTH_W-1:0] s3_period_ff, s3_period_in;

   assign sum_wide     = {1'b0, sum_ff} + (SUM_W+1)'(s2_raw_ff)
                         - (SUM_W+1)'(hist_q[AVG_DEPTH-1]);
   assign sum_in       = hist_shift ? sum_wide[SUM_W-1:0] : sum_ff;
   assign s3_valid_in  = advance ? s2_valid_ff : s3_valid_ff;
   assign s3_raw_in    = advance ? s2_raw_ff : s3_raw_ff;
   assign s3_width_in  = advance ? s2_width_ff : s3_width_ff;
   assign s3_period_in = advance ? s2_period_ff : s3_period_ff;

   // output stage: mean of the history through the reciprocal multiply
   logic [AVG_PROD_W-1:0] avg_prod;
   logic [WIDTH_W-1:0] rsp_width_ff, rsp_width_in;
   logic [DIST_W-1:0]  rsp_raw_ff, rsp_raw_in;
   logic [DIST_W-1:0]  rsp_avg_ff, rsp_avg_in;
   logic [WIDTH_W-1:0] rsp_period_ff, rsp_period_in;

   assign avg_prod      = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_RECIP);
   assign rsp_tvalid_in = advance ? s3_valid_ff : rsp_tvalid_ff;
   assign rsp_width_in  = advance ? s3_width_ff : rsp_width_ff;
   assign rsp_raw_in    = advance ? s3_raw_ff : rsp_raw_ff;
   assign rsp_avg_in    = advance ? avg_prod[AVG_K+DIST_W-1:AVG_K] : rsp_avg_ff;
   assign rsp_period_in = advance ? s3_period_ff : rsp_period_ff;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_rise_ff   <= '0;
         rise_period_ff <= '0;
         rise_count_ff  <= '0;
         sum_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         last_rise_ff   <= last_rise_in;
         rise_period_ff <= rise_period_in;
         rise_count_ff  <= rise_count_in;
         sum_ff         <= sum_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         s3_valid_ff    <= s3_valid_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_width_ff   <= s1_width_in;
      s1_period_ff  <= s1_period_in;
      s2_raw_ff     <= s2_raw_in;
      s2_width_ff   <= s2_width_in;
      s2_period_ff  <= s2_period_in;
      s3_raw_ff     <= s3_raw_in;
      s3_width_ff   <= s3_width_in;
      s3_period_ff  <= s3_period_in;
      rsp_width_ff  <= rsp_width_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_period_ff <= rsp_period_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_period_ff, rsp_avg_ff, rsp_raw_ff, rsp_width_ff};

   // a rising-edge transaction never enters the result pipeline
   a_rise_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> !s1_valid_ff)
      else $error("rising edge produced a pipeline entry");

   // a result only appears when the last stage held one
   a_rsp_from_s3: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(s3_valid_ff))
      else $error("response valid without a stage 3 entry");

   // running sum stays within the history's reach
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      (SUM_W+4)'(sum_ff) <= (SUM_W+4)'(AVG_DEPTH) * (SUM_W+4)'(DIST_MAX))
      else $error("running sum out of range");

   // raw and averaged distances never pass the largest echo
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_raw_ff <= DIST_MAX) && (rsp_avg_ff <= DIST_MAX))
      else $error("distance out of range");

endmodule
`default_nettype wire

// ===== tb/echo_pulse_range_averager_test.sv =====
// self-checking testbench for the echo pulse range averager
`timescale 1ns / 1ps
module echo_pulse_range_averager_test
   import epra_pkg::*;
();

   localparam int AVG_DEPTH      = 6;
   localparam int TICKS_PER_INCH = 148;
   localparam int LATENCY        = 3;     // pads the final drain wait
   localparam int HOLD_CYCLES    = 400;   // long rsp hold-off to back the block up
   localparam int PHASE_ITEMS    = 380;
   localparam int N_DIRECTED     = 25;

   // level of the captured edge, carried on req_tuser
   typedef enum logic {
      EDGE_FALL = 1'b0,
      EDGE_RISE = 1'b1
   } edge_kind_type;

   // one range result, last field in the low bits as on rsp_tdata
   typedef struct packed {
      logic [WIDTH_W-1:0] echo_period;
      logic [DIST_W-1:0]  distance_avg;
      logic [DIST_W-1:0]  distance_raw;
      logic [WIDTH_W-1:0] pulse_width;
   } range_result_type;

   typedef struct packed {
      edge_kind_type      kind;
      logic [STAMP_W-1:0] stamp;
      bit                 typed;    // 1: want holds the expected result as written
      range_result_type   want;
   } capture_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [15:0]        req_tdata  = '0;
   logic               req_tuser  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [55:0]        rsp_tdata;

   echo_pulse_range_averager #(
      .AVG_DEPTH(AVG_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: mirrors the block's rise stamp, period, rise count and history
   logic [STAMP_W-1:0] rise_stamp;
   logic [WIDTH_W-1:0] rise_span;
   int unsigned        rises_seen;
   logic [DIST_W-1:0]  inch_history [AVG_DEPTH];

   range_result_type pending_ranges [$];   // expected results, oldest first

   int unsigned idle_pct = 0;           // chance in 100 that the sender idles a cycle
   int unsigned stall_pct = 0;          // chance in 100 that rsp_tready drops a cycle
   logic        rsp_hold = 1'b0;
   event        hold_go;

   int unsigned edges_sent = 0;
   int unsigned falls_sent = 0;
   int unsigned ranges_checked = 0;
   int unsigned mismatch_count = 0;

   // modular 16-bit span; equal stamps stand for a full timer wrap
   function automatic logic [WIDTH_W-1:0] tick_span(logic [STAMP_W-1:0] from_stamp,
                                                    logic [STAMP_W-1:0] to_stamp);
      logic [STAMP_W-1:0] d;
      d = to_stamp - from_stamp;
      return (d == '0) ? WIDTH_W'(1 << STAMP_W) : {1'b0, d};
   endfunction

   task automatic clear_range_state();
      rise_stamp = '0;
      rise_span  = '0;
      rises_seen = 0;
      foreach (inch_history[i]) inch_history[i] = '0;
   endtask

   // advance the predictor by one capture; falling edges give a range result
   task automatic predict_range(input edge_kind_type kind, input logic [STAMP_W-1:0] stamp,
                                output bit produced, output range_result_type res);
      int unsigned inch_sum;
      logic [WIDTH_W-1:0] width;
      produced = 1'b0;
      res = '0;
      if (kind == EDGE_RISE) begin
         rise_span  = tick_span(rise_stamp, stamp);
         rise_stamp = stamp;
         if (rises_seen < 2) rises_seen++;
      end else begin
         width = tick_span(rise_stamp, stamp);
         for (int i = AVG_DEPTH - 1; i >= 1; i--) inch_history[i] = inch_history[i-1];
         inch_history[0] = DIST_W'(width / TICKS_PER_INCH);
         inch_sum = 0;
         foreach (inch_history[i]) inch_sum += inch_history[i];
         res.pulse_width  = width;
         res.distance_raw = inch_history[0];
         res.distance_avg = DIST_W'(inch_sum / AVG_DEPTH);
         res.echo_period  = (rises_seen >= 2) ? rise_span : '0;
         produced = 1'b1;
      end
   endtask

   // offer one capture transaction, wait for it to be taken, then log what it should give
   task automatic send_edge(input edge_kind_type kind, input logic [STAMP_W-1:0] stamp,
                            input bit typed = 1'b0, input range_result_type typed_want = '0);
      bit produced;
      range_result_type res;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= stamp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_range(kind, stamp, produced, res);
      edges_sent++;
      if (produced) begin
         falls_sent++;
         pending_ranges.push_back(typed ? typed_want : res);
      end
   endtask

   // pulse widths spread over short echoes, inch boundaries, the whole range and near-wraps
   function automatic logic [STAMP_W-1:0] pick_width();
      case ($urandom_range(0, 3))
         0: return STAMP_W'($urandom_range(1, 1500));
         1: return STAMP_W'(TICKS_PER_INCH * $urandom_range(0, 442)
                            + $urandom_range(0, 2) - 1);
         2: return STAMP_W'($urandom);
         default: return STAMP_W'($urandom_range(65000, 65535));
      endcase
   endfunction

   // mostly rise/fall pairs with random content, some stray single edges
   task automatic send_random_edges(input int unsigned count);
      int unsigned sent;
      logic [STAMP_W-1:0] start;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 8) begin
            start = STAMP_W'($urandom);
            send_edge(EDGE_RISE, start);
            send_edge(EDGE_FALL, start + pick_width());
            sent += 2;
         end else begin
            send_edge(edge_kind_type'($urandom_range(0, 1)), STAMP_W'($urandom));
            sent++;
         end
      end
   endtask

   task automatic wait_ranges_drained();
      req_tvalid <= 1'b0;
      while (pending_ranges.size() != 0) @(posedge clock);
   endtask

   // directed captures: full wraps, widths of 1 and 65535, inch boundaries,
   // falls before any rise, period before two rises, a history filled with the maximum
   capture_row_type directed_rows [N_DIRECTED] = '{
      '{EDGE_FALL, 16'h0000, 1'b1, '{17'd0, 9'd73,  9'd442, 17'h10000}},
      '{EDGE_FALL, 16'hFFFF, 1'b1, '{17'd0, 9'd147, 9'd442, 17'd65535}},
      '{EDGE_FALL, 16'h0001, 1'b1, '{17'd0, 9'd147, 9'd0,   17'd1}},
      '{EDGE_RISE, 16'h0064, 1'b0, '0},
      '{EDGE_FALL, 16'h00F8, 1'b0, '0},
      '{EDGE_FALL, 16'h00F7, 1'b0, '0},
      '{EDGE_RISE, 16'h0064, 1'b0, '0},
      '{EDGE_FALL, 16'h0064, 1'b0, '0},
      '{EDGE_RISE, 16'hFFFF, 1'b0, '0},
      '{EDGE_FALL, 16'h0000, 1'b0, '0},
      '{EDGE_RISE, 16'h0000, 1'b0, '0},
      '{EDGE_FALL, 16'hFFFF, 1'b0, '0},
      '{EDGE_RISE, 16'h5555, 1'b0, '0},
      '{EDGE_FALL, 16'hAAAA, 1'b0, '0},
      '{EDGE_RISE, 16'hAAAA, 1'b0, '0},
      '{EDGE_FALL, 16'hAAAA, 1'b0, '0},
      '{EDGE_FALL, 16'hAAAA, 1'b0, '0},
      '{EDGE_FALL, 16'hAAAA, 1'b0, '0},
      '{EDGE_FALL, 16'hAAAA, 1'b0, '0},
      '{EDGE_FALL, 16'hAAAA, 1'b0, '0},
      '{EDGE_FALL, 16'hAAAA, 1'b0, '0},
      '{EDGE_FALL, 16'hAAAB, 1'b0, '0},
      '{EDGE_RISE, 16'h8000, 1'b0, '0},
      '{EDGE_FALL, 16'h7F88, 1'b0, '0},
      '{EDGE_FALL, 16'h7F87, 1'b0, '0}
   };

   // receiver: random stalls, forced low while a hold-off runs
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // long hold-off, counted here so the sender keeps going meanwhile
   initial begin
      forever begin
         @(hold_go);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // result checker: every rsp transaction against the oldest expectation
   always @(posedge clock) begin
      range_result_type got;
      range_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pulse_width  = rsp_tdata[16:0];
         got.distance_raw = rsp_tdata[25:17];
         got.distance_avg = rsp_tdata[34:26];
         got.echo_period  = rsp_tdata[51:35];
         if (pending_ranges.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("tb: unexpected result width=%0d raw=%0d avg=%0d period=%0d",
                        got.pulse_width, got.distance_raw, got.distance_avg,
                        got.echo_period);
         end else begin
            want = pending_ranges.pop_front();
            ranges_checked++;
            if (got.pulse_width !== want.pulse_width ||
                got.distance_raw !== want.distance_raw ||
                got.distance_avg !== want.distance_avg ||
                got.echo_period !== want.echo_period) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $write("tb: mismatch at result %0d: width %0d/%0d raw %0d/%0d ",
                         ranges_checked, want.pulse_width, got.pulse_width,
                         want.distance_raw, got.distance_raw);
                  $display("avg %0d/%0d period %0d/%0d (expected/actual)",
                           want.distance_avg, got.distance_avg,
                           want.echo_period, got.echo_period);
               end
            end
         end
      end
   end

   // main sequence
   initial begin
      int unsigned guard;
      clear_range_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, no idling
      foreach (directed_rows[i])
         send_edge(directed_rows[i].kind, directed_rows[i].stamp,
                   directed_rows[i].typed, directed_rows[i].want);
      wait_ranges_drained();

      // back-pressure: rsp held off while captures keep coming
      -> hold_go;
      send_random_edges(80);
      wait_ranges_drained();

      idle_pct = 0;  stall_pct = 0;  send_random_edges(PHASE_ITEMS);  wait_ranges_drained();
      idle_pct = 50; stall_pct = 0;  send_random_edges(PHASE_ITEMS);  wait_ranges_drained();
      idle_pct = 0;  stall_pct = 50; send_random_edges(PHASE_ITEMS);  wait_ranges_drained();
      idle_pct = 14; stall_pct = 14; send_random_edges(PHASE_ITEMS);
      req_tvalid <= 1'b0;

      guard = 0;
      while (pending_ranges.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY * 4) @(posedge clock);
      if (pending_ranges.size() != 0) begin
         mismatch_count += pending_ranges.size();
         $display("tb: %0d expected results never arrived", pending_ranges.size());
      end

      $display("tb: %0d capture transactions sent, %0d falling edges, %0d results checked",
               edges_sent, falls_sent, ranges_checked);
      $display("tb: covered wraps, edge extremes, a full history and idle/stall mixes");
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/epra_pkg.sv
hdl/epra_cell.sv
hdl/echo_pulse_range_averager.sv
tb/echo_pulse_range_averager_test.sv
